FILE: src/eida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity id allocator package
// Shared widths, codes and the control/status structs between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package eida_pkg;

   // fixed field widths of the ports
   localparam int KIND_W   = 3;
   localparam int ENT_W    = 8;
   localparam int CTYPE_W  = 3;
   localparam int CDATA_W  = 32;
   localparam int STATUS_W = 3;
   localparam int TCNT_W   = 4;

   // parameter defaults
   localparam int DEF_MAX_IDS    = 256;
   localparam int DEF_MAX_TYPES  = 8;
   localparam int DEF_DATA_WIDTH = 32;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GET     = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ENTITY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd5;

   // source of the response payload
   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_POP,
      SEL_MINT,
      SEL_GET
   } out_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic                load;
      logic                rd_slot;
      logic                rd_last;
      logic                slot_clr;
      logic                slot_inc;
      logic                type_req;
      logic                type_clr;
      logic                type_inc;
      logic                swap_wr;
      logic                append_wr;
      logic                pop;
      logic                push;
      logic                out_we;
      logic [STATUS_W-1:0] code;
      out_sel_type         sel;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              ent_ok;
      logic              type_ok;
      logic              free_empty;
      logic              ids_full;
      logic              slot_end;
      logic              hit;
      logic              type_end;
      logic              rsp_free;
   } stat_type;

endpackage

FILE: src/eida_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module eida_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic [AW-1:0]    addr,
   input  logic             we,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/eida_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity id allocator datapath
// Request capture, id counters, free stack, per-type tables and the
// response register.
// ----------------------------------------------------------------------------
module eida_dpath
   import eida_pkg::*;
#(
   parameter int MAX_IDS    = DEF_MAX_IDS,
   parameter int MAX_TYPES  = DEF_MAX_TYPES,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ENT_W-1:0]    req_entity,
   input  logic [CTYPE_W-1:0]  req_comp_type,
   input  logic [CDATA_W-1:0]  req_comp_data,
   input  logic                csr_we,
   input  logic [TCNT_W-1:0]   csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ENT_W-1:0]    rsp_new_entity,
   output logic                rsp_found,
   output logic [CDATA_W-1:0]  rsp_data_out,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int SW        = $clog2(MAX_IDS);
   localparam int CNT_W     = SW + 1;
   localparam int CW        = (CNT_W > ENT_W) ? CNT_W : ENT_W;
   localparam int TW        = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int TCW       = $clog2(MAX_TYPES + 1);
   localparam int KW        = (TCW > TCNT_W) ? TCW : TCNT_W;
   localparam int MEM_DEPTH = MAX_TYPES * MAX_IDS;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [CNT_W-1:0] ID_LIM = CNT_W'(MAX_IDS);

   // request capture
   logic [KIND_W-1:0]     req_kind_ff;
   logic [ENT_W-1:0]      req_ent_ff;
   logic [CTYPE_W-1:0]    req_type_ff;
   logic [DATA_WIDTH-1:0] req_data_ff;

   // control state
   logic [TCNT_W-1:0] type_count_ff;
   logic [CNT_W-1:0]  next_id_ff;
   logic [CNT_W-1:0]  free_depth_ff;
   logic [CNT_W-1:0]  count_ff [MAX_TYPES];
   logic [CNT_W-1:0]  slot_ff;
   logic [TCW-1:0]    cur_type_ff;
   logic              rsp_valid_ff;

   // response payload
   logic [STATUS_W-1:0] status_ff;
   logic [ENT_W-1:0]    new_ent_ff;
   logic                found_ff;
   logic [CDATA_W-1:0]  data_out_ff;

   logic [KW-1:0]         active;
   logic [CNT_W-1:0]      cnt_cur;
   logic                  cnt_room;
   logic [CNT_W-1:0]      mslot;
   logic [AW-1:0]         maddr;
   logic                  mem_re;
   logic                  mem_we;
   logic [SW-1:0]         ment_wdata;
   logic [DATA_WIDTH-1:0] mdata_wdata;
   logic [SW-1:0]         ment_rd;
   logic [DATA_WIDTH-1:0] mdata_rd;
   logic [CNT_W-1:0]      stk_idx;
   logic                  stk_we;
   logic [SW-1:0]         stk_rd;
   logic                  rsp_take;

   // derived terms
   assign active   = (KW'(type_count_ff) < KW'(MAX_TYPES)) ? KW'(type_count_ff)
                                                          : KW'(MAX_TYPES);
   assign cnt_cur  = count_ff[cur_type_ff[TW-1:0]];
   assign cnt_room = cnt_cur < ID_LIM;
   assign rsp_take = rsp_valid_ff & ~rsp_stall;

   // table addressing: slot under scan, last entry, or append position
   always_comb begin
      if (cmd.rd_last) begin
         mslot = cnt_cur - CNT_W'(1);
      end else if (cmd.append_wr) begin
         mslot = cnt_cur;
      end else begin
         mslot = slot_ff;
      end
   end

   assign maddr       = AW'(cur_type_ff) * AW'(MAX_IDS) + AW'(mslot);
   assign mem_re      = cmd.rd_slot | cmd.rd_last;
   assign mem_we      = cmd.swap_wr | (cmd.append_wr & cnt_room);
   assign ment_wdata  = cmd.swap_wr ? ment_rd  : SW'(req_ent_ff);
   assign mdata_wdata = cmd.swap_wr ? mdata_rd : req_data_ff;

   eida_ram #(.WIDTH(SW), .DEPTH(MEM_DEPTH)) u_ent_ram (
      .clock   (clock),
      .addr    (maddr),
      .we      (mem_we),
      .wdata   (ment_wdata),
      .re      (mem_re),
      .rd_data (ment_rd)
   );

   eida_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MEM_DEPTH)) u_data_ram (
      .clock   (clock),
      .addr    (maddr),
      .we      (mem_we),
      .wdata   (mdata_wdata),
      .re      (mem_re),
      .rd_data (mdata_rd)
   );

   // free stack: pop reads top, push writes at depth
   assign stk_idx = cmd.pop ? (free_depth_ff - CNT_W'(1)) : free_depth_ff;
   assign stk_we  = cmd.push & (free_depth_ff < ID_LIM);

   eida_ram #(.WIDTH(SW), .DEPTH(MAX_IDS)) u_stack_ram (
      .clock   (clock),
      .addr    (stk_idx[SW-1:0]),
      .we      (stk_we),
      .wdata   (SW'(req_ent_ff)),
      .re      (cmd.pop),
      .rd_data (stk_rd)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_kind_ff <= req_kind;
         req_ent_ff  <= req_entity;
         req_type_ff <= req_comp_type;
         req_data_ff <= DATA_WIDTH'(req_comp_data);
      end
   end

   // counters, type register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         type_count_ff <= '0;
         next_id_ff    <= CNT_W'(1);
         free_depth_ff <= '0;
         slot_ff       <= '0;
         cur_type_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_TYPES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            type_count_ff <= csr_wdata;
         end
         if (cmd.out_we && cmd.sel == SEL_MINT) begin
            next_id_ff <= next_id_ff + CNT_W'(1);
         end
         if (cmd.pop) begin
            free_depth_ff <= free_depth_ff - CNT_W'(1);
         end else if (stk_we) begin
            free_depth_ff <= free_depth_ff + CNT_W'(1);
         end
         if (cmd.slot_clr) begin
            slot_ff <= '0;
         end else if (cmd.slot_inc) begin
            slot_ff <= slot_ff + CNT_W'(1);
         end
         if (cmd.type_clr) begin
            cur_type_ff <= '0;
         end else if (cmd.type_req) begin
            cur_type_ff <= TCW'(req_type_ff);
         end else if (cmd.type_inc) begin
            cur_type_ff <= cur_type_ff + TCW'(1);
         end
         if (cmd.swap_wr) begin
            count_ff[cur_type_ff[TW-1:0]] <= cnt_cur - CNT_W'(1);
         end else if (cmd.append_wr && cnt_room) begin
            count_ff[cur_type_ff[TW-1:0]] <= cnt_cur + CNT_W'(1);
         end
         if (cmd.out_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.out_we) begin
         status_ff <= cmd.code;
         found_ff  <= (cmd.sel == SEL_GET);
         case (cmd.sel)
            SEL_POP: begin
               new_ent_ff  <= ENT_W'(stk_rd);
               data_out_ff <= '0;
            end
            SEL_MINT: begin
               new_ent_ff  <= ENT_W'(next_id_ff);
               data_out_ff <= '0;
            end
            SEL_GET: begin
               new_ent_ff  <= '0;
               data_out_ff <= CDATA_W'(mdata_rd);
            end
            default: begin
               new_ent_ff  <= '0;
               data_out_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_new_entity = new_ent_ff;
   assign rsp_found      = found_ff;
   assign rsp_data_out   = data_out_ff;

   // status to the controller
   assign stat.kind       = req_kind_ff;
   assign stat.ent_ok     = (req_ent_ff != '0) && (CW'(req_ent_ff) < CW'(next_id_ff));
   assign stat.type_ok    = KW'(req_type_ff) < active;
   assign stat.free_empty = (free_depth_ff == '0);
   assign stat.ids_full   = (next_id_ff >= ID_LIM);
   assign stat.slot_end   = (slot_ff >= cnt_cur);
   assign stat.hit        = (CW'(ment_rd) == CW'(req_ent_ff));
   assign stat.type_end   = (KW'(cur_type_ff) >= active);
   assign stat.rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   // checks
   a_depth_lim: assert property (@(posedge clock) disable iff (reset)
      free_depth_ff <= ID_LIM) else $error("free stack depth beyond limit");

   a_next_id: assert property (@(posedge clock) disable iff (reset)
      (next_id_ff != '0) && (next_id_ff <= ID_LIM)) else $error("next id out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (free_depth_ff != '0)) else $error("pop from empty free stack");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we |=> rsp_valid_ff) else $error("response word lost");

endmodule

FILE: src/eida_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity id allocator controller
// Sequences one request: decode, table scan, swap-remove, append, push and
// response handoff.
// ----------------------------------------------------------------------------
module eida_ctrl
   import eida_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_TYPE_CHK,
      S_SCAN,
      S_COMPARE,
      S_SWAP,
      S_APPEND,
      S_PUSH,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   out_sel_type         sel_ff, sel_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.code = code_ff;
      cmd.sel  = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            code_in  = ST_OK;
            sel_in   = SEL_NONE;
            if (stat.kind == KIND_CREATE) begin
               if (!stat.free_empty) begin
                  cmd.pop = 1'b1;
                  sel_in  = SEL_POP;
               end else if (stat.ids_full) begin
                  code_in = ST_EXHAUSTED;
               end else begin
                  sel_in = SEL_MINT;
               end
            end else if (stat.kind == KIND_DESTROY) begin
               if (!stat.ent_ok) begin
                  code_in = ST_BAD_ENTITY;
               end else begin
                  cmd.type_clr = 1'b1;
                  state_in     = S_TYPE_CHK;
               end
            end else if (stat.kind == KIND_ADD || stat.kind == KIND_REMOVE ||
                         stat.kind == KIND_GET) begin
               if (!stat.type_ok) begin
                  code_in = ST_BAD_TYPE;
               end else if (!stat.ent_ok) begin
                  code_in = ST_BAD_ENTITY;
               end else begin
                  cmd.type_req = 1'b1;
                  cmd.slot_clr = 1'b1;
                  state_in     = S_SCAN;
               end
            end
         end
         // destroy: walk registered types
         S_TYPE_CHK: begin
            if (stat.type_end) begin
               state_in = S_PUSH;
            end else begin
               cmd.slot_clr = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.slot_end) begin
               if (stat.kind == KIND_ADD) begin
                  state_in = S_APPEND;
               end else if (stat.kind == KIND_DESTROY) begin
                  cmd.type_inc = 1'b1;
                  state_in     = S_TYPE_CHK;
               end else begin
                  code_in  = ST_ABSENT;
                  state_in = S_FINISH;
               end
            end else begin
               cmd.rd_slot = 1'b1;
               state_in    = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (stat.hit) begin
               if (stat.kind == KIND_ADD) begin
                  code_in  = ST_DUPLICATE;
                  state_in = S_FINISH;
               end else if (stat.kind == KIND_GET) begin
                  sel_in   = SEL_GET;
                  state_in = S_FINISH;
               end else begin
                  cmd.rd_last = 1'b1;
                  state_in    = S_SWAP;
               end
            end else begin
               cmd.slot_inc = 1'b1;
               state_in     = S_SCAN;
            end
         end
         // last entry moves into the hit slot
         S_SWAP: begin
            cmd.swap_wr = 1'b1;
            if (stat.kind == KIND_DESTROY) begin
               cmd.type_inc = 1'b1;
               state_in     = S_TYPE_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_APPEND: begin
            cmd.append_wr = 1'b1;
            state_in      = S_FINISH;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.out_we = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
         sel_ff   <= SEL_NONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         sel_ff   <= sel_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // checks
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_DISPATCH)) else $error("load without dispatch");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we |-> stat.rsp_free) else $error("response written while held");

   a_one_wr: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.swap_wr, cmd.append_wr, cmd.rd_slot, cmd.rd_last}))
      else $error("table port used twice");

endmodule

FILE: src/entity_id_allocator_component_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity id allocator with component tables
// Mints and recycles entity ids and keeps per-type (entity, data) tables.
// ----------------------------------------------------------------------------
// Usage:
//  - Request words (req_*) are taken when req_valid is high and req_stall low.
//    One request is worked on at a time; req_stall is high while it runs.
//  - Every request gives exactly one response word (rsp_*), held in an
//    output register until taken (rsp_valid high, rsp_stall low). The next
//    request is taken while that word still waits.
//  - csr_we/csr_wdata write the number of registered types; write it only
//    while no request is in flight.
//  - Create and rejected requests go from the dispatch step straight to the
//    finishing step. Add, remove and get scan one type table through the
//    single-port table memory, a scan and a compare step per entry; destroy
//    scans every registered type the same way, with a type check per type.
//  - Reset clears ids, free stack depth, table fills and the type count;
//    no clearing pass is needed.
//  - A stalled response only delays the finishing step of the next request.
// ----------------------------------------------------------------------------
module entity_id_allocator_component_table_core
   import eida_pkg::*;
#(
   parameter int MAX_IDS    = DEF_MAX_IDS,
   parameter int MAX_TYPES  = DEF_MAX_TYPES,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ENT_W-1:0]    req_entity,
   input  logic [CTYPE_W-1:0]  req_comp_type,
   input  logic [CDATA_W-1:0]  req_comp_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ENT_W-1:0]    rsp_new_entity,
   output logic                rsp_found,
   output logic [CDATA_W-1:0]  rsp_data_out,
   input  logic                csr_we,
   input  logic [TCNT_W-1:0]   csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   eida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   eida_dpath #(
      .MAX_IDS    (MAX_IDS),
      .MAX_TYPES  (MAX_TYPES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_kind),
      .req_entity     (req_entity),
      .req_comp_type  (req_comp_type),
      .req_comp_data  (req_comp_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_new_entity (rsp_new_entity),
      .rsp_found      (rsp_found),
      .rsp_data_out   (rsp_data_out),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

FILE: dv/entity_id_allocator_component_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity id allocator testbench
// Drives create, destroy, add, remove, get and unused-kind words in random bursts, keeps
// its own model of the id pool and type tables, and checks every response
// word field by field against the predicted one.
// ----------------------------------------------------------------------------
module entity_id_allocator_component_table_core_test;
   import eida_pkg::*;

   localparam int NUM_IDS   = DEF_MAX_IDS;
   localparam int NUM_TYPES = DEF_MAX_TYPES;

   // kinds with no operation behind them
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ENT_W-1:0]   entity;
      logic [CTYPE_W-1:0] ctype;
      logic [CDATA_W-1:0] cdata;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENT_W-1:0]    new_ent;
      logic                found;
      logic [CDATA_W-1:0]  dout;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [ENT_W-1:0]    req_entity = '0;
   logic [CTYPE_W-1:0]  req_comp_type = '0;
   logic [CDATA_W-1:0]  req_comp_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ENT_W-1:0]    rsp_new_entity;
   logic                rsp_found;
   logic [CDATA_W-1:0]  rsp_data_out;
   logic                csr_we = 1'b0;
   logic [TCNT_W-1:0]   csr_wdata = '0;

   entity_id_allocator_component_table_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_entity(req_entity),
      .req_comp_type(req_comp_type), .req_comp_data(req_comp_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_new_entity(rsp_new_entity),
      .rsp_found(rsp_found), .rsp_data_out(rsp_data_out),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // allocator model state
   int unsigned types_on;
   int unsigned mint_id;
   int unsigned pool_depth;
   int unsigned pool [NUM_IDS];
   int unsigned fill [NUM_TYPES];
   int unsigned tab_ent [NUM_TYPES][NUM_IDS];
   logic [CDATA_W-1:0] tab_dat [NUM_TYPES][NUM_IDS];

   req_word_type pending_words[$];
   rsp_word_type due_words[$];
   int  errors = 0;
   bit  hold_on = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  stall_phase = 0;
   int  stall_mode = 0;
   int  mint_hint = 1;
   bit  accepted_q = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int slot_of(int unsigned t, int unsigned e);
      for (int i = 0; i < fill[t]; i++)
         if (tab_ent[t][i] == e) return i;
      return -1;
   endfunction

   function automatic void take_out(int unsigned t, int s);
      fill[t]--;
      tab_ent[t][s] = tab_ent[t][fill[t]];
      tab_dat[t][s] = tab_dat[t][fill[t]];
   endfunction

   // predicted response for one accepted word, updating the model
   function automatic rsp_word_type allocate_predict(req_word_type w);
      rsp_word_type r;
      int unsigned act;
      int s;
      bit ent_good;
      r = '0;
      r.status = ST_OK;
      act = (types_on < NUM_TYPES) ? types_on : NUM_TYPES;
      ent_good = (w.entity != 0) && (w.entity < mint_id);
      case (w.kind)
         KIND_CREATE: begin
            if (pool_depth > 0) begin
               pool_depth--;
               r.new_ent = ENT_W'(pool[pool_depth]);
            end else if (mint_id >= NUM_IDS) begin
               r.status = ST_EXHAUSTED;
            end else begin
               r.new_ent = ENT_W'(mint_id);
               mint_id++;
            end
         end
         KIND_DESTROY: begin
            if (!ent_good) begin
               r.status = ST_BAD_ENTITY;
            end else begin
               for (int t = 0; t < act; t++) begin
                  s = slot_of(t, w.entity);
                  if (s >= 0) take_out(t, s);
               end
               if (pool_depth < NUM_IDS) begin
                  pool[pool_depth] = 32'(w.entity);
                  pool_depth++;
               end
            end
         end
         KIND_ADD, KIND_REMOVE, KIND_GET: begin
            if (w.ctype >= act) r.status = ST_BAD_TYPE;
            else if (!ent_good) r.status = ST_BAD_ENTITY;
            else begin
               s = slot_of(w.ctype, w.entity);
               if (w.kind == KIND_ADD) begin
                  if (s >= 0) r.status = ST_DUPLICATE;
                  else if (fill[w.ctype] < NUM_IDS) begin
                     tab_ent[w.ctype][fill[w.ctype]] = 32'(w.entity);
                     tab_dat[w.ctype][fill[w.ctype]] = w.cdata;
                     fill[w.ctype]++;
                  end
               end else if (s < 0) begin
                  r.status = ST_ABSENT;
               end else if (w.kind == KIND_REMOVE) begin
                  take_out(w.ctype, s);
               end else begin
                  r.found = 1'b1;
                  r.dout  = tab_dat[w.ctype][s];
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic void push_word(logic [KIND_W-1:0] k, int e, int t, logic [31:0] d);
      req_word_type w;
      w.kind = k; w.entity = ENT_W'(e); w.ctype = CTYPE_W'(t); w.cdata = d;
      pending_words.push_back(w);
   endfunction

   // pick an entity that is mostly live, sometimes out of range
   function automatic int pick_entity();
      int lim;
      lim = (mint_hint > 1) ? mint_hint - 1 : 1;
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(0, 255);
         default: return $urandom_range(1, lim + 1);
      endcase
   endfunction

   // driver: bursts and gaps, changes on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_q) begin
            if (gap_left > 0) gap_left--;
            if (!hold_on && gap_left == 0 && pending_words.size() > 0) begin
               req_word_type w;
               w = pending_words.pop_front();
               req_kind <= w.kind; req_entity <= w.entity;
               req_comp_type <= w.ctype; req_comp_data <= w.cdata;
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         // receiver stall pattern
         stall_phase++;
         if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (stall_phase % 7) < 3;
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // monitor: accept on rising edge, predict and check
   always @(posedge clock) begin
      accepted_q <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_word_type w;
            w.kind = req_kind; w.entity = req_entity;
            w.ctype = req_comp_type; w.cdata = req_comp_data;
            due_words.push_back(allocate_predict(w));
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_status), 32'd0);
            end else begin
               rsp_word_type e;
               e = due_words.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch("status", 32'(rsp_status), 32'(e.status));
               if (rsp_new_entity !== e.new_ent)
                  report_mismatch("new_entity", 32'(rsp_new_entity), 32'(e.new_ent));
               if (rsp_found !== e.found)
                  report_mismatch("found", 32'(rsp_found), 32'(e.found));
               if (rsp_data_out !== e.dout)
                  report_mismatch("data_out", rsp_data_out, e.dout);
            end
         end
      end
   end

   // wait until the last word is taken and its response is back
   task automatic drain();
      wait (pending_words.size() == 0);
      @(posedge clock);
      wait (!req_valid);
      while (due_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_types(int n);
      @(negedge clock);
      csr_wdata <= TCNT_W'(n); csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      types_on = n;
   endtask

   task automatic random_phase(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < 15) begin
            push_word(KIND_CREATE, $urandom_range(0, 255), $urandom_range(0, 7), $urandom);
            if (mint_hint < 255) mint_hint++;
         end else if (k < 25)
            push_word(KIND_DESTROY, pick_entity(), $urandom_range(0, 7), $urandom);
         else if (k < 55)
            push_word(KIND_ADD, pick_entity(), $urandom_range(0, 7), $urandom);
         else if (k < 70)
            push_word(KIND_REMOVE, pick_entity(), $urandom_range(0, 7), $urandom);
         else if (k < 97)
            push_word(KIND_GET, pick_entity(), $urandom_range(0, 7), $urandom);
         else
            push_word(KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                      pick_entity(), $urandom_range(0, 7), $urandom);
      end
   endtask

   initial begin
      types_on = 0; mint_id = 1; pool_depth = 0;
      foreach (fill[t]) fill[t] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: unregistered types, then basic life cycle
      push_word(KIND_ADD, 1, 0, 32'h1);
      push_word(KIND_DESTROY, 0, 0, 0);
      push_word(KIND_CREATE, 0, 0, 0);
      push_word(KIND_GET, 1, 0, 0);
      push_word(KIND_UNUSED_LO, 255, 7, 32'hFFFF_FFFF);
      push_word(KIND_UNUSED_HI, 0, 0, 0);
      drain();
      write_types(8);
      push_word(KIND_CREATE, 0, 0, 0);
      push_word(KIND_ADD, 1, 7, 32'hFFFF_FFFF);
      push_word(KIND_ADD, 1, 7, 32'h0);
      push_word(KIND_ADD, 2, 0, 32'hA5A5_5A5A);
      push_word(KIND_ADD, 0, 0, 32'h1);
      push_word(KIND_ADD, 255, 3, 32'h1);
      push_word(KIND_ADD, 2, 3, 32'h1234);
      push_word(KIND_GET, 1, 7, 0);
      push_word(KIND_GET, 2, 3, 0);
      push_word(KIND_REMOVE, 1, 7, 0);
      push_word(KIND_REMOVE, 1, 7, 0);
      push_word(KIND_GET, 1, 7, 0);
      push_word(KIND_DESTROY, 2, 0, 0);
      push_word(KIND_DESTROY, 2, 0, 0);
      push_word(KIND_GET, 2, 3, 0);
      push_word(KIND_CREATE, 0, 0, 0);
      push_word(KIND_CREATE, 0, 0, 0);
      mint_hint = 3;
      drain();

      // random phases across type counts
      write_types(3);
      random_phase(80);
      drain();
      write_types(15);
      random_phase(80);
      // hold the sender part way through until every response is back
      wait (pending_words.size() < 40);
      hold_on = 1'b1;
      @(posedge clock);
      wait (!req_valid);
      while (due_words.size() != 0) @(posedge clock);
      hold_on = 1'b0;
      drain();
      write_types(1);
      random_phase(30);
      drain();
      write_types(0);
      random_phase(15);
      drain();
      write_types(8);
      // run the id space out
      for (int i = 0; i < 260; i++) push_word(KIND_CREATE, 0, 0, 0);
      mint_hint = 255;
      random_phase(60);
      drain();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: entity_id_allocator_component_table_core.f
src/eida_pkg.sv
src/eida_ram.sv
src/eida_dpath.sv
src/eida_ctrl.sv
src/entity_id_allocator_component_table_core.sv
dv/entity_id_allocator_component_table_core_test.sv
